[sv/quaternion_to_euler_core_defines.svh]
// Assertion helpers for the quaternion to Euler core.
`ifndef QUATERNION_TO_EULER_CORE_DEFINES_SVH
`define QUATERNION_TO_EULER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define QTE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `QTE_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define QTE_ASSERT(lbl, clk, rstn, prop, msg)
`define QTE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[sv/qte_pkg.sv]
package qte_pkg;

    localparam int CORDIC_STAGES_DEF = 16;

    localparam int QW = 16;     // input component width
    localparam int PW = 32;     // component product width
    localparam int TW = 34;     // t0..t4 width
    localparam int CW = 37;     // CORDIC x/y datapath width
    localparam int ZW = 21;     // angle accumulator width, Q16
    localparam int SW = 30;     // clamped t2 width
    localparam int RW = 58;     // square root remainder width
    localparam int SQ_STEPS = 29;
    localparam int ROOT_W = 29;
    localparam int PITCH_EXTRA = 2 + SQ_STEPS;  // square, subtract, root steps

    localparam int ROLL_W = 16;
    localparam int PITCH_W = 15;
    localparam int YAW_W = 16;

    localparam logic signed [TW-1:0] ONE_Q28 = TW'(64'sd268435456);
    localparam logic signed [ZW-1:0] PI_Q16 = ZW'(205887);
    localparam logic signed [ZW:0] ANG_LIM = (ZW+1)'(25736);
    localparam logic signed [ZW:0] HALF_LIM = (ZW+1)'(12868);

    function automatic logic signed [ZW-1:0] atan_q16(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0: v = ZW'(51472);
            1: v = ZW'(30385);
            2: v = ZW'(16055);
            3: v = ZW'(8150);
            4: v = ZW'(4091);
            5: v = ZW'(2047);
            6: v = ZW'(1024);
            7: v = ZW'(512);
            8: v = ZW'(256);
            9: v = ZW'(128);
            10: v = ZW'(64);
            11: v = ZW'(32);
            12: v = ZW'(16);
            13: v = ZW'(8);
            14: v = ZW'(4);
            15: v = ZW'(2);
            16: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q16 angle to Q13 with round half up, then saturate to +/- lim
    function automatic logic signed [ZW:0] to_q13(input logic signed [ZW-1:0] a,
                                                  input logic signed [ZW:0] lim);
        logic signed [ZW:0] r;
        r = ((ZW+1)'(a) + (ZW+1)'(4)) >>> 3;
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

[sv/qte_delay.sv]
module qte_delay #(
    parameter int W = 8,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
        end
    end

    for (genvar k = 1; k < DEPTH; k++) begin : g_tap
        always_ff @(posedge aclk) begin
            if (en) begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];
endmodule

[sv/qte_isqrt.sv]
module qte_isqrt (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [qte_pkg::RW-1:0]        n_in,
    output logic [qte_pkg::ROOT_W-1:0]    root
);
    import qte_pkg::*;

    logic [RW-1:0] n_reg [SQ_STEPS];
    logic [RW-1:0] r_reg [SQ_STEPS];

    // one result bit per stage, restoring method from the top bit pair down
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQ_STEPS - 1 - k));
        logic [RW-1:0] n_cur;
        logic [RW-1:0] r_cur;
        logic [RW-1:0] trial;
        logic [RW-1:0] n_next;
        logic [RW-1:0] r_next;

        if (k == 0) begin : g_first
            assign n_cur = n_in;
            assign r_cur = '0;
        end else begin : g_rest
            assign n_cur = n_reg[k-1];
            assign r_cur = r_reg[k-1];
        end

        always_comb begin
            trial = r_cur + BIT;
            if (n_cur >= trial) begin
                n_next = n_cur - trial;
                r_next = (r_cur >> 1) + BIT;
            end else begin
                n_next = n_cur;
                r_next = r_cur >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k] <= n_next;
                r_reg[k] <= r_next;
            end
        end
    end

    assign root = r_reg[SQ_STEPS-1][ROOT_W-1:0];
endmodule

[sv/qte_cordic.sv]
module qte_cordic #(
    parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [qte_pkg::CW-1:0] y_in,
    input  logic signed [qte_pkg::CW-1:0] x_in,
    output logic signed [qte_pkg::ZW-1:0] z_out
);
    import qte_pkg::*;

    logic signed [CW-1:0] x_reg [STAGES+1];
    logic signed [CW-1:0] y_reg [STAGES+1];
    logic signed [ZW-1:0] z_reg [STAGES+1];

    // left half plane: turn the vector by pi first
    always_ff @(posedge aclk) begin
        if (en) begin
            if (x_in < 0) begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= (y_in >= 0) ? PI_Q16 : -PI_Q16;
            end else begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] < 0) begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - atan_q16(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + atan_q16(i);
                end
            end
        end
    end

    assign z_out = z_reg[STAGES];
endmodule

[sv/quaternion_to_euler_core.sv]
// Quaternion to Euler angles. Takes one quaternion (qx, qy, qz, qw, signed Q1.14)
// per word and returns roll and yaw in signed Q2.13 radians, pitch in Q1.13; the
// quaternion is not normalized and pitch is the negated arcsine of the clamped
// 2(wy - zx) term. Fully pipelined: a new word is taken every cycle unless the
// output is stalled, and the longest path, which roll and yaw are delayed to
// match, is the pitch path (square, 29-step square root pipeline, then the CORDIC
// vectoring pipeline of CORDIC_STAGES + 1 stages). Back-pressure on m_tready
// freezes the whole pipeline; nothing is dropped or duplicated.
`include "quaternion_to_euler_core_defines.svh"
module quaternion_to_euler_core #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // qx[15:0], qy[31:16], qz[47:32], qw[63:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // roll[15:0], pitch[30:16], yaw[46:31], zero[47]
);
    import qte_pkg::*;

    localparam int VLD_DEPTH = CORDIC_STAGES + PITCH_EXTRA + 3;

    logic adv;
    logic [VLD_DEPTH-1:0] vld_reg;
    logic m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    logic signed [QW-1:0] qx, qy, qz, qw;
    logic signed [PW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg;
    logic signed [PW-1:0] zx_reg, wz_reg, xy_reg, zz_reg;
    logic signed [TW-1:0] t0_reg, t1_reg, t3_reg, t4_reg;
    logic signed [SW-1:0] t2_reg;
    logic signed [TW-1:0] t2_next;
    logic signed [2*SW-1:0] sq_full;
    logic [RW-1:0] sq_reg;
    logic [RW-1:0] n_reg;
    logic [ROOT_W-1:0] root;
    logic [SW-1:0] t2_dly;
    logic signed [ZW-1:0] roll_z, yaw_z, pitch_z;
    logic [ZW-1:0] roll_dly, yaw_dly;
    logic signed [ZW:0] roll_q, yaw_q, pitch_q;
    logic signed [PITCH_W-1:0] pitch_neg;

    assign adv = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    assign qx = s_tdata[15:0];
    assign qy = s_tdata[31:16];
    assign qz = s_tdata[47:32];
    assign qw = s_tdata[63:48];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= {vld_reg[VLD_DEPTH-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[VLD_DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            wy_reg <= qw * qy;
            zx_reg <= qz * qx;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            zz_reg <= qz * qz;
        end
    end

    assign t2_next = (TW'(wy_reg) - TW'(zx_reg)) <<< 1;

    always_ff @(posedge aclk) begin
        if (adv) begin
            t0_reg <= (TW'(wx_reg) + TW'(yz_reg)) <<< 1;
            t1_reg <= ONE_Q28 - ((TW'(xx_reg) + TW'(yy_reg)) <<< 1);
            t3_reg <= (TW'(wz_reg) + TW'(xy_reg)) <<< 1;
            t4_reg <= ONE_Q28 - ((TW'(yy_reg) + TW'(zz_reg)) <<< 1);
            // clamp to [-1, 1]
            if (t2_next > ONE_Q28) begin
                t2_reg <= SW'(ONE_Q28);
            end else if (t2_next < -ONE_Q28) begin
                t2_reg <= SW'(-ONE_Q28);
            end else begin
                t2_reg <= SW'(t2_next);
            end
        end
    end

    // full-width square, never above 2^56
    assign sq_full = t2_reg * t2_reg;

    // 1 - t2^2 in Q56, fed to the square root pipeline
    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg <= sq_full[RW-1:0];
            n_reg <= (RW'(1) << 56) - sq_reg;
        end
    end

    qte_isqrt u_isqrt (
        .aclk (aclk),
        .en   (adv),
        .n_in (n_reg),
        .root (root)
    );

    qte_delay #(.W(SW), .DEPTH(PITCH_EXTRA)) u_t2_dly (
        .aclk (aclk),
        .en   (adv),
        .din  (t2_reg),
        .dout (t2_dly)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .aclk  (aclk),
        .en    (adv),
        .y_in  (CW'(t0_reg)),
        .x_in  (CW'(t1_reg)),
        .z_out (roll_z)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .aclk  (aclk),
        .en    (adv),
        .y_in  (CW'(t3_reg)),
        .x_in  (CW'(t4_reg)),
        .z_out (yaw_z)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .aclk  (aclk),
        .en    (adv),
        .y_in  (CW'($signed(t2_dly))),
        .x_in  ($signed(CW'(root))),
        .z_out (pitch_z)
    );

    // align roll and yaw with the longer pitch path
    qte_delay #(.W(ZW), .DEPTH(PITCH_EXTRA)) u_roll_dly (
        .aclk (aclk),
        .en   (adv),
        .din  (roll_z),
        .dout (roll_dly)
    );

    qte_delay #(.W(ZW), .DEPTH(PITCH_EXTRA)) u_yaw_dly (
        .aclk (aclk),
        .en   (adv),
        .din  (yaw_z),
        .dout (yaw_dly)
    );

    assign roll_q = to_q13($signed(roll_dly), ANG_LIM);
    assign yaw_q = to_q13($signed(yaw_dly), ANG_LIM);
    assign pitch_q = to_q13(pitch_z, HALF_LIM);
    assign pitch_neg = -PITCH_W'(pitch_q);

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= {1'b0, YAW_W'(yaw_q), pitch_neg, ROLL_W'(roll_q)};
        end
    end

    `QTE_ASSERT(a_roll_range, aclk, aresetn, m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd25736 && $signed(m_tdata[15:0]) >= -16'sd25736), "roll out of range")
    `QTE_ASSERT(a_pitch_range, aclk, aresetn, m_tvalid |-> ($signed(m_tdata[30:16]) <= 15'sd12868 && $signed(m_tdata[30:16]) >= -15'sd12868), "pitch out of range")
    `QTE_ASSERT(a_yaw_range, aclk, aresetn, m_tvalid |-> ($signed(m_tdata[46:31]) <= 16'sd25736 && $signed(m_tdata[46:31]) >= -16'sd25736), "yaw out of range")
    `QTE_ASSERT(a_stall_hold, aclk, aresetn, !s_tready |=> $stable(vld_reg), "pipeline moved while stalled")
    `QTE_ASSERT_NEVER(a_pad_zero, aclk, aresetn, m_tvalid && m_tdata[47], "pad bit set")
endmodule

[bench/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = qte_pkg::CORDIC_STAGES_DEF;
    localparam int LATENCY = STAGES + 35;
    localparam longint ONE_Q28 = 64'sd268435456;
    localparam longint PI_Q16 = 64'sd205887;
    localparam longint ANG_LIM = 64'sd25736;
    localparam longint HALF_LIM = 64'sd12868;
    localparam int N_RANDOM = 1550;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [15:0] qw;
        logic signed [15:0] qz;
        logic signed [15:0] qy;
        logic signed [15:0] qx;
    } quat_t;

    typedef struct packed {
        logic        pad;
        logic [15:0] yaw;
        logic [14:0] pitch;
        logic [15:0] roll;
    } euler_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    quat_t  quat_pending[$];
    euler_t angles_expected[$];
    int     send_idle_pct = 30;
    int     recv_idle_pct = 74;
    bit     stim_done = 1'b0;
    int     error_count = 0;
    longint cycle_count = 0;

    quaternion_to_euler_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_step(int i);
        longint tbl[17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2, 1};
        return (i < 17) ? tbl[i] : 0;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint acc, xs, ys;
        acc = 0;
        if (x < 0) begin
            acc = (y >= 0) ? PI_Q16 : -PI_Q16;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y < 0) begin
                x = x - ys;
                y = y + xs;
                acc = acc - atan_step(i);
            end else begin
                x = x + ys;
                y = y - xs;
                acc = acc + atan_step(i);
            end
        end
        return acc;
    endfunction

    function automatic longint root_floor(longint n);
        longint res, b;
        res = 0;
        b = 64'sd1 << 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >>> 1) + b;
            end else begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res;
    endfunction

    function automatic longint round_q13(longint a, longint lim);
        longint r;
        r = shr_floor(a + 4, 3);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic euler_t quat_to_euler(quat_t q);
        longint x, y, z, w, t0, t1, t2, t3, t4, c, pitch;
        euler_t e;
        x = q.qx; y = q.qy; z = q.qz; w = q.qw;
        t0 = 2 * (w * x + y * z);
        t1 = ONE_Q28 - 2 * (x * x + y * y);
        t2 = 2 * (w * y - z * x);
        t3 = 2 * (w * z + x * y);
        t4 = ONE_Q28 - 2 * (y * y + z * z);
        if (t2 > ONE_Q28) t2 = ONE_Q28;
        if (t2 < -ONE_Q28) t2 = -ONE_Q28;
        c = root_floor(ONE_Q28 * ONE_Q28 - t2 * t2);
        pitch = -round_q13(vector_angle(t2, c), HALF_LIM);
        e.pad = 1'b0;
        e.roll = 16'(round_q13(vector_angle(t0, t1), ANG_LIM));
        e.pitch = 15'(pitch);
        e.yaw = 16'(round_q13(vector_angle(t3, t4), ANG_LIM));
        return e;
    endfunction

    function automatic int rand_comp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return int'($signed(16'($urandom)));
        if (r < 16) begin
            case ($urandom_range(0, 4))
                0: return 16384;
                1: return -16384;
                2: return 0;
                3: return 32767;
                default: return -32768;
            endcase
        end
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    // unit quaternion with random content, scaled to Q1.14
    function automatic quat_t rand_unit();
        real a, b, c, d, n;
        quat_t q;
        a = real'($urandom_range(0, 2000)) - 1000.0;
        b = real'($urandom_range(0, 2000)) - 1000.0;
        c = real'($urandom_range(0, 2000)) - 1000.0;
        d = real'($urandom_range(0, 2000)) - 1000.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n == 0.0) n = 1.0;
        q.qx = 16'($rtoi(a / n * 16384.0));
        q.qy = 16'($rtoi(b / n * 16384.0));
        q.qz = 16'($rtoi(c / n * 16384.0));
        q.qw = 16'($rtoi(d / n * 16384.0));
        return q;
    endfunction

    task automatic add_quat(int x, int y, int z, int w);
        quat_t q;
        q.qx = 16'(x); q.qy = 16'(y); q.qz = 16'(z); q.qw = 16'(w);
        quat_pending.push_back(q);
    endtask

    task automatic drain();
        while (quat_pending.size() != 0 || angles_expected.size() != 0) @(posedge aclk);
    endtask

    initial begin
        quat_t q;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        // identity, zero, extremes, gimbal lock both ways, left half plane
        add_quat(0, 0, 0, 16384);
        add_quat(0, 0, 0, 0);
        add_quat(16384, 0, 0, 0);
        add_quat(0, 16384, 0, 0);
        add_quat(0, 0, 16384, 0);
        add_quat(0, 0, 0, -16384);
        add_quat(-16384, 0, 0, 0);
        add_quat(0, 11585, 0, 11585);
        add_quat(0, -11585, 0, 11585);
        add_quat(16384, 16384, 16384, 16384);
        add_quat(-16384, -16384, -16384, -16384);
        add_quat(32767, 32767, 32767, 32767);
        add_quat(-32768, -32768, -32768, -32768);
        add_quat(-32768, 32767, -32768, 32767);
        add_quat(-1, -1, -1, -1);
        add_quat(11585, 0, 0, -11585);
        add_quat(-11585, 0, 0, -11585);
        add_quat(0, 0, 11585, -11585);
        add_quat(0, 0, -11585, -11585);
        add_quat(0, 16384, 0, 16384);
        add_quat(0, -16384, 0, 16384);
        add_quat(16384, 0, 16384, 0);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 74 : 0;
            recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 30 : 0;
            for (int i = 0; i < N_RANDOM / 3; i++) begin
                if ($urandom_range(0, 99) < 70) begin
                    q = rand_unit();
                    quat_pending.push_back(q);
                end else begin
                    add_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
                end
            end
            drain();
        end
        repeat (LATENCY + 10) @(posedge aclk);
        stim_done = 1'b1;
    end

    // driver: hold the word until accepted, then advance
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (s_tvalid) void'(quat_pending.pop_front());
                if (quat_pending.size() > (s_tvalid ? 1 : 0) - (s_tvalid ? 1 : 0)
                    && quat_pending.size() != 0
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= quat_pending[0];
                    angles_expected.push_back(quat_to_euler(quat_pending[0]));
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        euler_t got, want;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (angles_expected.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                error_count <= error_count + 1;
            end else begin
                want = angles_expected.pop_front();
                if (got.roll !== want.roll || got.pitch !== want.pitch
                    || got.yaw !== want.yaw) begin
                    $display("%0t: mismatch expected roll %h pitch %h yaw %h, actual roll %h pitch %h yaw %h",
                             $time, want.roll, want.pitch, want.yaw,
                             got.roll, got.pitch, got.yaw);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (stim_done) begin
            if (error_count == 0 && angles_expected.size() == 0) begin
                $display("*** PASSED ***");
            end else begin
                $display("*** FAILED ***");
            end
            $finish;
        end else if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end
endmodule
